### sv/txos_pkg.sv
`default_nettype none

package txos_pkg;

    // field widths
    localparam int STATUS_W = 8;
    localparam int COUNT_W  = 16;
    localparam int WINDOW_W = 8;

    // slot layout: slot 0 is reserved and never counts
    localparam int NUM_SLOTS   = 8;
    localparam int NUM_BLOCKED = NUM_SLOTS - 1;

    // status codes and saturation limits
    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] INTERNAL_CODE = STATUS_W'(7);
    localparam logic [STATUS_W-1:0] REASON_NONE   = {STATUS_W{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [WINDOW_W-1:0] WINDOW_MAX    = {WINDOW_W{1'b1}};

    // command codes
    typedef enum logic [1:0] {
        CMD_RECORD   = 2'd0,
        CMD_SNAPSHOT = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_code_t;

    // command beat
    typedef struct packed {
        logic [1:0]          command;
        logic [STATUS_W-1:0] outcome_code;
    } cmd_beat_t;

    // snapshot beat
    typedef struct packed {
        logic [COUNT_W-1:0]  blocked_slot1;
        logic [COUNT_W-1:0]  blocked_slot2;
        logic [COUNT_W-1:0]  blocked_slot3;
        logic [COUNT_W-1:0]  blocked_slot4;
        logic [COUNT_W-1:0]  blocked_slot5;
        logic [COUNT_W-1:0]  blocked_slot6;
        logic [COUNT_W-1:0]  blocked_internal;
        logic [WINDOW_W-1:0] window_count;
        logic [STATUS_W-1:0] last_reason;
    } snap_beat_t;

endpackage

`default_nettype wire

### sv/tx_outcome_statistics_counters.sv
// Transmit outcome statistics.
// Command channel (cmd_valid / cmd_stall / cmd): each beat carries a command
// and a transmit status. Record bumps the matching blocked slot (statuses 1
// to 6, and the internal-error code in the last slot), bumps the window count
// and latches any non-OK status as the last reason. Snapshot emits one beat
// on the snap channel with all counts, then clears them. Clear zeroes all
// counts silently; the unused command code does nothing.
// Snapshot channel (snap_valid / snap_stall / snap): one beat per snapshot.
// Path: a snapshot command is captured in the input register, then processed
// and loaded into the snapshot register, which drives snap_valid.
// Throughput: one command per cycle while cmd_stall is low, set by the single
// input register feeding the counter update and the snapshot output register.
// A waiting snapshot beat does not block records or clears; a second snapshot
// holds in the input register until the snapshot register is taken, and
// cmd_stall stays high while it waits.
// Reset: all counts and the window count go to zero, the last reason to 255
// (none), and both channels come up empty.
`default_nettype none

module tx_outcome_statistics_counters #(
    parameter logic [txos_pkg::STATUS_W-1:0] INTERNAL_CODE = txos_pkg::INTERNAL_CODE
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire txos_pkg::cmd_beat_t  cmd,
    output logic                      snap_valid,
    input  wire logic                 snap_stall,
    output txos_pkg::snap_beat_t      snap
);

    logic                                cmd_valid_reg;
    logic                                cmd_valid_next;
    txos_pkg::cmd_beat_t                 cmd_reg;
    logic [txos_pkg::COUNT_W-1:0]        cnt_reg  [txos_pkg::NUM_BLOCKED];
    logic [txos_pkg::COUNT_W-1:0]        cnt_next [txos_pkg::NUM_BLOCKED];
    logic [txos_pkg::WINDOW_W-1:0]       window_reg;
    logic [txos_pkg::WINDOW_W-1:0]       window_next;
    logic [txos_pkg::STATUS_W-1:0]       reason_reg;
    logic [txos_pkg::STATUS_W-1:0]       reason_next;
    logic                                snap_valid_reg;
    logic                                snap_valid_next;
    txos_pkg::snap_beat_t                snap_reg;
    txos_pkg::snap_beat_t                snap_next;
    logic                                cmd_take;
    logic                                go;
    logic                                is_snapshot;
    logic [txos_pkg::NUM_BLOCKED-1:0]    slot_hit;

    // held command proceeds unless it is a snapshot blocked by a stalled result
    assign is_snapshot = (cmd_reg.command == txos_pkg::CMD_SNAPSHOT);
    assign go          = cmd_valid_reg && (!is_snapshot || !snap_valid_reg || !snap_stall);
    assign cmd_stall   = cmd_valid_reg && !go;
    assign cmd_take    = cmd_valid && !cmd_stall;

    // input register control
    always_comb
    begin
        if (cmd_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (go)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    // status to slot decode, last slot is the internal-error code
    always_comb
    begin
        for (int i = 0; i < txos_pkg::NUM_BLOCKED; i++)
        begin
            if (i == txos_pkg::NUM_BLOCKED - 1)
            begin
                slot_hit[i] = (cmd_reg.outcome_code == INTERNAL_CODE);
            end
            else
            begin
                slot_hit[i] = (cmd_reg.outcome_code == txos_pkg::STATUS_W'(i + 1));
            end
        end
    end

    // counter update and snapshot capture
    always_comb
    begin
        for (int i = 0; i < txos_pkg::NUM_BLOCKED; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        window_next = window_reg;
        reason_next = reason_reg;

        snap_next.blocked_slot1    = cnt_reg[0];
        snap_next.blocked_slot2    = cnt_reg[1];
        snap_next.blocked_slot3    = cnt_reg[2];
        snap_next.blocked_slot4    = cnt_reg[3];
        snap_next.blocked_slot5    = cnt_reg[4];
        snap_next.blocked_slot6    = cnt_reg[5];
        snap_next.blocked_internal = cnt_reg[6];
        snap_next.window_count     = window_reg;
        snap_next.last_reason      = reason_reg;

        if (go)
        begin
            unique case (cmd_reg.command) inside
                txos_pkg::CMD_RECORD:
                begin
                    for (int i = 0; i < txos_pkg::NUM_BLOCKED; i++)
                    begin
                        if (slot_hit[i] && (cnt_reg[i] != txos_pkg::COUNT_MAX))
                        begin
                            cnt_next[i] = cnt_reg[i] + txos_pkg::COUNT_W'(1);
                        end
                    end
                    if (window_reg != txos_pkg::WINDOW_MAX)
                    begin
                        window_next = window_reg + txos_pkg::WINDOW_W'(1);
                    end
                    if (cmd_reg.outcome_code != txos_pkg::STATUS_OK)
                    begin
                        reason_next = cmd_reg.outcome_code;
                    end
                end
                txos_pkg::CMD_SNAPSHOT, txos_pkg::CMD_CLEAR:
                begin
                    for (int i = 0; i < txos_pkg::NUM_BLOCKED; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    window_next = '0;
                    reason_next = txos_pkg::REASON_NONE;
                end
                default:
                begin
                    window_next = window_reg;
                end
            endcase
        end
    end

    // snapshot output register control
    always_comb
    begin
        if (go && is_snapshot)
        begin
            snap_valid_next = 1'b1;
        end
        else if (!snap_stall)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
    end

    // control and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            snap_valid_reg <= 1'b0;
            for (int i = 0; i < txos_pkg::NUM_BLOCKED; i++)
            begin
                cnt_reg[i] <= '0;
            end
            window_reg <= '0;
            reason_reg <= txos_pkg::REASON_NONE;
        end
        else
        begin
            cmd_valid_reg  <= cmd_valid_next;
            snap_valid_reg <= snap_valid_next;
            for (int i = 0; i < txos_pkg::NUM_BLOCKED; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            window_reg <= window_next;
            reason_reg <= reason_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (go && is_snapshot)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // a snapshot that proceeds always shows a result beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && is_snapshot) |=> snap_valid)
        else $error("snapshot did not produce a result beat");

    // snapshot and clear leave the window empty and the last reason at none
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && (cmd_reg.command == txos_pkg::CMD_SNAPSHOT ||
                cmd_reg.command == txos_pkg::CMD_CLEAR))
        |=> (window_reg == '0 && reason_reg == txos_pkg::REASON_NONE))
        else $error("window not cleared");

    // stall only comes from a held snapshot blocked by a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (cmd_valid_reg && is_snapshot && snap_valid_reg && snap_stall))
        else $error("unexpected command stall");

    // the window count only moves on a processed command
    assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(window_reg))
        else $error("window count changed without a command");

endmodule

`default_nettype wire
